FILE: hdl/dhlg_pkg.sv
// ----------------------------------------------------------------------------
// dhlg_pkg
// Types, codes and constants shared by the dwell hysteresis level governor.
// ----------------------------------------------------------------------------
package dhlg_pkg;

  localparam int LEVEL_W = 3;

  localparam logic [LEVEL_W-1:0] TOP_LEVEL  = 3'd5;
  localparam logic [2:0]         BUDGET_MAX = 3'd5;
  localparam logic [63:0]        HOLD_MS    = 64'd10000;

  localparam logic [12:0] DWELL_CRITICAL   = 13'd400;
  localparam logic [12:0] DWELL_CORRECTIVE = 13'd600;
  localparam logic [12:0] DWELL_RAISE      = 13'd5000;

  localparam logic FUNC_EVAL = 1'b0;
  localparam logic FUNC_SYNC = 1'b1;

  localparam logic [10:0] LOAD_FULL = 11'd1024;

  typedef enum logic [2:0] {
    CFG_MIN_VALID_TARGET   = 3'd0,
    CFG_MAX_VALID_TARGET   = 3'd1,
    CFG_CORRECTIVE_RATE_Q8 = 3'd2,
    CFG_CRITICAL_RATE_Q8   = 3'd3,
    CFG_RELEASE_RATE_Q8    = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic        func;
    logic        actuator_ok;
    logic        pressure_active;
    logic [9:0]  target_rate;
    logic [17:0] measured_rate_q8;
    logic [63:0] now_ms;
    logic [2:0]  step_budget;
    logic        load_present;
    logic [10:0] load_q10;
    logic [2:0]  observed_level_in;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               constrained;
    logic               accepted;
  } out_item_t;

  typedef struct packed {
    logic               enforcing;
    logic [LEVEL_W-1:0] active_level;
    logic [LEVEL_W-1:0] pending_level;
    logic [63:0]        pending_since;
    logic [63:0]        release_since;
    logic [63:0]        missing_since;
    logic [63:0]        last_time;
    logic [9:0]         last_target;
    logic [LEVEL_W-1:0] observed_level;
  } gov_state_t;

  // floor(load * 4999 / 1024000) for load in 0..1024, by threshold compare
  function automatic logic [2:0] load_reduction(input logic [10:0] load);
    logic [2:0] red;
    red = 3'd0;
    if (load >= 11'd205) red = 3'd1;
    if (load >= 11'd410) red = 3'd2;
    if (load >= 11'd615) red = 3'd3;
    if (load >= 11'd820) red = 3'd4;
    return red;
  endfunction

endpackage

FILE: hdl/dwell_hysteresis_level_governor_unit.sv
// ----------------------------------------------------------------------------
// dwell_hysteresis_level_governor_unit
// Governs a work level 1..5 from periodic rate samples with dwell hysteresis.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle unless in_stall is high and returns
// one result per item: an input register feeds the decision logic,
// which updates the governor state and loads the result register in the same
// cycle. in_stall rises only while the result register holds an item that
// out_stall keeps back and the input register is full. Configuration writes
// are always ready and take effect at the next edge.
module dwell_hysteresis_level_governor_unit
  import dhlg_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [17:0] cfg_data
);

  logic [9:0]  min_target_r, max_target_r;
  logic [17:0] corrective_r, critical_r, release_r;

  logic       s1_vld_r, out_vld_r;
  in_item_t   s1_data_r;
  out_item_t  out_data_r, res_nxt;
  gov_state_t state_r, state_nxt;
  logic       advance, in_take;

  logic [10:0]        load_sat;
  logic [2:0]         load_red;
  logic [LEVEL_W-1:0] load_tgt;

  logic                 invalid, time_back, hold_ok;
  logic [63:0]          since;
  logic [LEVEL_W-1:0]   act;
  logic                 go_cand, crit;
  logic [3:0]           attack;
  logic signed [4:0]    cand;
  logic [LEVEL_W-1:0]   cand_lvl;
  logic [12:0]          dwell;

  assign cfg_ready = 1'b1;
  assign advance   = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = s1_vld_r && !advance;
  assign in_take   = in_valid && !in_stall;
  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  assign load_sat = (s1_data_r.load_q10 > LOAD_FULL) ? LOAD_FULL : s1_data_r.load_q10;
  assign load_red = load_reduction(load_sat);

  always_comb begin
    if (!s1_data_r.load_present) begin
      load_tgt = TOP_LEVEL;
    end else if (LEVEL_W'(load_red) >= TOP_LEVEL) begin
      load_tgt = LEVEL_W'(1);
    end else begin
      load_tgt = TOP_LEVEL - LEVEL_W'(load_red);
    end
  end

  assign invalid = !s1_data_r.actuator_ok || (s1_data_r.target_rate == 10'd0) ||
                   (s1_data_r.target_rate < min_target_r) ||
                   (s1_data_r.target_rate > max_target_r) ||
                   (s1_data_r.step_budget < 3'd1) || (s1_data_r.step_budget > BUDGET_MAX);
  assign time_back = (state_r.last_time != 64'd0) && (s1_data_r.now_ms < state_r.last_time);

  always_comb begin
    state_nxt = state_r;
    res_nxt   = '0;
    since     = '0;
    hold_ok   = 1'b0;
    act       = '0;
    go_cand   = 1'b0;
    crit      = 1'b0;
    attack    = '0;
    cand      = '0;
    cand_lvl  = '0;
    dwell     = '0;
    if (s1_data_r.func == FUNC_SYNC) begin
      if (s1_data_r.observed_level_in >= LEVEL_W'(1) &&
          s1_data_r.observed_level_in <= TOP_LEVEL) begin
        if (!state_r.enforcing) state_nxt.observed_level = s1_data_r.observed_level_in;
        res_nxt.accepted = 1'b1;
      end
    end else if (invalid) begin
      state_nxt = '0;
    end else begin
      if (state_r.last_target != 10'd0 && state_r.last_target != s1_data_r.target_rate) begin
        state_nxt.pending_level = state_r.active_level;
        state_nxt.pending_since = s1_data_r.now_ms;
      end
      if (time_back) state_nxt = '0;
      state_nxt.last_target = s1_data_r.target_rate;
      state_nxt.last_time   = s1_data_r.now_ms;
      if (!s1_data_r.pressure_active || s1_data_r.measured_rate_q8 == 18'd0) begin
        // hold the active level while pressure or telemetry is missing, drop after HOLD_MS
        if (!s1_data_r.pressure_active) begin
          state_nxt.missing_since = '0;
          since = state_nxt.release_since;
        end else begin
          state_nxt.release_since = '0;
          since = state_nxt.missing_since;
        end
        if (state_nxt.enforcing) begin
          if (since == 64'd0) since = s1_data_r.now_ms;
          if (!s1_data_r.pressure_active) state_nxt.release_since = since;
          else state_nxt.missing_since = since;
          hold_ok = (s1_data_r.now_ms >= since) && ((s1_data_r.now_ms - since) < HOLD_MS);
          if (hold_ok) begin
            res_nxt.level       = state_nxt.active_level;
            res_nxt.constrained = 1'b1;
          end else begin
            state_nxt = '0;
          end
        end
      end else begin
        state_nxt.release_since = '0;
        state_nxt.missing_since = '0;
        go_cand = 1'b1;
        if (state_nxt.active_level == '0) begin
          state_nxt.pending_since = s1_data_r.now_ms;
          state_nxt.enforcing     = 1'b1;
          if (state_nxt.observed_level != '0) begin
            state_nxt.active_level  = state_nxt.observed_level;
            state_nxt.pending_level = state_nxt.observed_level;
          end else begin
            state_nxt.active_level  = TOP_LEVEL;
            state_nxt.pending_level = (load_tgt < TOP_LEVEL) ? load_tgt : TOP_LEVEL;
            res_nxt.level           = TOP_LEVEL;
            res_nxt.constrained     = 1'b1;
            go_cand                 = 1'b0;
          end
        end
        if (go_cand) begin
          act  = state_nxt.active_level;
          cand = $signed({2'b00, act});
          if (s1_data_r.measured_rate_q8 <= corrective_r && act > LEVEL_W'(1)) begin
            crit   = s1_data_r.measured_rate_q8 <= critical_r;
            attack = {1'b0, s1_data_r.step_budget} +
                     {3'b000, (crit && s1_data_r.step_budget > 3'd1)};
            if (attack > {1'b0, TOP_LEVEL}) attack = {1'b0, TOP_LEVEL};
            cand  = $signed({2'b00, act}) - $signed({1'b0, attack});
            dwell = crit ? DWELL_CRITICAL : DWELL_CORRECTIVE;
          end else if (s1_data_r.measured_rate_q8 >= release_r && act < TOP_LEVEL) begin
            cand  = $signed({2'b00, act}) + 5'sd1;
            dwell = DWELL_RAISE;
          end
          if ($signed({2'b00, load_tgt}) < cand) begin
            cand  = $signed({2'b00, load_tgt});
            dwell = (dwell == '0 || dwell > DWELL_CORRECTIVE) ? DWELL_CORRECTIVE : dwell;
          end
          if (cand < 5'sd1) cand_lvl = LEVEL_W'(1);
          else if (cand > $signed({2'b00, TOP_LEVEL})) cand_lvl = TOP_LEVEL;
          else cand_lvl = cand[LEVEL_W-1:0];
          if (cand_lvl != state_nxt.pending_level) begin
            state_nxt.pending_level = cand_lvl;
            state_nxt.pending_since = s1_data_r.now_ms;
          end else if (cand_lvl != act && s1_data_r.now_ms >= state_nxt.pending_since &&
                       (s1_data_r.now_ms - state_nxt.pending_since) >= {51'd0, dwell}) begin
            state_nxt.active_level  = cand_lvl;
            state_nxt.pending_level = cand_lvl;
            state_nxt.pending_since = s1_data_r.now_ms;
          end
          state_nxt.enforcing = 1'b1;
          res_nxt.level       = state_nxt.active_level;
          res_nxt.constrained = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_target_r <= 10'd30;
      max_target_r <= 10'd240;
      corrective_r <= 18'd14336;
      critical_r   <= 18'd11520;
      release_r    <= 18'd15616;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MIN_VALID_TARGET:   min_target_r <= cfg_data[9:0];
        CFG_MAX_VALID_TARGET:   max_target_r <= cfg_data[9:0];
        CFG_CORRECTIVE_RATE_Q8: corrective_r <= cfg_data;
        CFG_CRITICAL_RATE_Q8:   critical_r   <= cfg_data;
        CFG_RELEASE_RATE_Q8:    release_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      state_r   <= '0;
    end else begin
      if (in_take) s1_vld_r <= 1'b1;
      else if (advance) s1_vld_r <= 1'b0;
      if (advance) begin
        out_vld_r <= 1'b1;
        state_r   <= state_nxt;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) s1_data_r <= in_data;
    if (advance) out_data_r <= res_nxt;
  end

  a_enforce_level: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.enforcing |-> (state_r.active_level != '0 && state_r.active_level <= TOP_LEVEL))
    else $error("enforcing without a valid active level");

  a_idle_no_level: assert property (@(posedge clk) disable iff (!rst_n)
    !state_r.enforcing |-> state_r.active_level == '0)
    else $error("active level set while not enforcing");

  a_sync_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_data_r.accepted) |-> (out_data_r.level == '0 && !out_data_r.constrained))
    else $error("sync result carries a level");

  a_constrained_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_data_r.constrained) |-> out_data_r.level != '0)
    else $error("constrained result without a level");

  a_stall_only_full: assert property (@(posedge clk)
    in_stall |-> (s1_vld_r && out_vld_r && out_stall))
    else $error("input stalled while the pipeline can move");

endmodule

FILE: tb/dwell_hysteresis_level_governor_unit_tb.sv
// ----------------------------------------------------------------------------
// dwell_hysteresis_level_governor_unit_tb
// Self-checking regression for the dwell hysteresis level governor. A
// scoreboard class mirrors the governor state and rate registers, predicts one
// result per accepted item and checks the result stream in order. Stimulus is
// a short directed sequence followed by random sample episodes under several
// register settings, with random gaps on the input and random output stalls.
// ----------------------------------------------------------------------------
import dhlg_pkg::*;

class governor_scoreboard;
  logic [9:0]  min_target, max_target;
  logic [17:0] corrective_q8, critical_q8, release_q8;
  bit          enforcing;
  int          active_level, pending_level, observed_level;
  bit [63:0]   pending_since, release_since, missing_since, last_time;
  bit [9:0]    last_target;
  out_item_t   expected_levels[$];
  int          mismatches;
  int          checked;

  function new();
    min_target    = 10'd30;
    max_target    = 10'd240;
    corrective_q8 = 18'd14336;
    critical_q8   = 18'd11520;
    release_q8    = 18'd15616;
    mismatches    = 0;
    checked       = 0;
    clear_governor();
  endfunction

  function void clear_governor();
    enforcing      = 1'b0;
    active_level   = 0;
    pending_level  = 0;
    pending_since  = '0;
    release_since  = '0;
    missing_since  = '0;
    last_time      = '0;
    last_target    = '0;
    observed_level = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [17:0] val);
    case (idx)
      CFG_MIN_VALID_TARGET:   min_target    = val[9:0];
      CFG_MAX_VALID_TARGET:   max_target    = val[9:0];
      CFG_CORRECTIVE_RATE_Q8: corrective_q8 = val;
      CFG_CRITICAL_RATE_Q8:   critical_q8   = val;
      CFG_RELEASE_RATE_Q8:    release_q8    = val;
      default: ;
    endcase
  endfunction

  function int clamp_level(int v);
    if (v < 1) return 1;
    if (v > int'(TOP_LEVEL)) return int'(TOP_LEVEL);
    return v;
  endfunction

  function out_item_t pack_result(int lvl, bit cons, bit acc);
    out_item_t r;
    r.level       = lvl[LEVEL_W-1:0];
    r.constrained = cons;
    r.accepted    = acc;
    return r;
  endfunction

  // hold the active level while pressure or telemetry is missing, drop after HOLD_MS
  function out_item_t hold_level(bit on_release, bit [63:0] now);
    bit [63:0] since;
    if (!enforcing) return pack_result(0, 1'b0, 1'b0);
    since = on_release ? release_since : missing_since;
    if (since == 0) since = now;
    if (on_release) release_since = since;
    else missing_since = since;
    if (now >= since && now - since < HOLD_MS) return pack_result(active_level, 1'b1, 1'b0);
    clear_governor();
    return pack_result(0, 1'b0, 1'b0);
  endfunction

  function out_item_t govern(in_item_t it);
    int          load_level, cand, attack, budget, top;
    int unsigned load;
    bit [63:0]   now, dwell;
    bit          crit;
    top    = int'(TOP_LEVEL);
    now    = it.now_ms;
    budget = int'(it.step_budget);
    dwell  = '0;
    if (it.func == FUNC_SYNC) begin
      if (it.observed_level_in < 1 || int'(it.observed_level_in) > top)
        return pack_result(0, 1'b0, 1'b0);
      if (!enforcing) observed_level = int'(it.observed_level_in);
      return pack_result(0, 1'b0, 1'b1);
    end
    if (!it.actuator_ok || it.target_rate == '0 || it.target_rate < min_target ||
        it.target_rate > max_target || budget < 1 || budget > int'(BUDGET_MAX)) begin
      clear_governor();
      return pack_result(0, 1'b0, 1'b0);
    end
    load_level = top;
    if (it.load_present) begin
      load = (it.load_q10 > LOAD_FULL) ? int'(LOAD_FULL) : int'(it.load_q10);
      load_level = clamp_level(top - int'((load * 4999) / 1024000));
    end
    if (last_target != 0 && last_target != it.target_rate) begin
      pending_level = active_level;
      pending_since = now;
    end
    if (last_time != 0 && now < last_time) clear_governor();
    last_target = it.target_rate;
    last_time   = now;
    if (!it.pressure_active) begin
      missing_since = '0;
      return hold_level(1'b1, now);
    end
    release_since = '0;
    if (it.measured_rate_q8 == '0) return hold_level(1'b0, now);
    missing_since = '0;
    if (active_level == 0 && observed_level > 0) begin
      active_level  = observed_level;
      pending_level = active_level;
      pending_since = now;
      enforcing     = 1'b1;
    end else if (active_level == 0) begin
      active_level  = top;
      pending_level = (load_level < top) ? load_level : top;
      pending_since = now;
      enforcing     = 1'b1;
      return pack_result(active_level, 1'b1, 1'b0);
    end
    cand = active_level;
    if (it.measured_rate_q8 <= corrective_q8 && active_level > 1) begin
      crit   = it.measured_rate_q8 <= critical_q8;
      attack = clamp_level(budget + ((crit && budget > 1) ? 1 : 0));
      cand   = active_level - attack;
      dwell  = crit ? DWELL_CRITICAL : DWELL_CORRECTIVE;
    end else if (it.measured_rate_q8 >= release_q8 && active_level < top) begin
      cand  = active_level + 1;
      dwell = DWELL_RAISE;
    end
    if (load_level < cand) begin
      cand = load_level;
      if (dwell == 0 || dwell > DWELL_CORRECTIVE) dwell = DWELL_CORRECTIVE;
    end
    cand = clamp_level(cand);
    if (cand != pending_level) begin
      pending_level = cand;
      pending_since = now;
    end else if (cand != active_level && now >= pending_since) begin
      if (now - pending_since >= dwell) begin
        active_level  = cand;
        pending_level = active_level;
        pending_since = now;
      end
    end
    enforcing = 1'b1;
    return pack_result(active_level, 1'b1, 1'b0);
  endfunction

  function void note_sample(in_item_t it);
    expected_levels.push_back(govern(it));
  endfunction

  function void check_level(out_item_t got);
    out_item_t want;
    checked++;
    if (expected_levels.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d unexpected: level %0d constrained %0b accepted %0b",
                 checked, got.level, got.constrained, got.accepted);
      return;
    end
    want = expected_levels.pop_front();
    if (got.level !== want.level || got.constrained !== want.constrained ||
        got.accepted !== want.accepted) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                 checked, want.level, want.constrained, want.accepted,
                 got.level, got.constrained, got.accepted);
    end
  endfunction
endclass

module dwell_hysteresis_level_governor_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          STALL_LIMIT      = 4000;
  localparam int          MAX_WAIT         = 13;
  localparam logic [2:0]  CFG_UNUSED_INDEX = 3'd7;
  localparam logic [17:0] RATE_MAX         = 18'h3FFFF;

  typedef enum int {
    EP_LOW,
    EP_HIGH,
    EP_MIXED,
    EP_PRESSURE_OFF,
    EP_TELEMETRY_OFF,
    EP_NOISE
  } episode_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [17:0] cfg_data  = '0;

  governor_scoreboard sb;
  int        cfg_writes    = 0;
  int        settings_used = 1;
  int        items_sent    = 0;
  bit        send_calm     = 1'b0;
  bit        recv_calm     = 1'b0;
  bit        no_idle       = 1'b0;
  bit [63:0] gen_time;
  bit [9:0]  gen_target;
  episode_t  episode;
  int        episode_left  = 0;
  int        step_max      = 300;

  dwell_hysteresis_level_governor_unit dut (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_sample(in_data);
      if (out_valid && !out_stall) sb.check_level(out_data);
      if (cfg_valid && cfg_ready) begin
        sb.write_reg(cfg_index, cfg_data);
        cfg_writes++;
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
    $display("dwell_hysteresis_level_governor_unit regression: fail");
    $finish;
  end

  initial begin : result_sink
    int wait_cycles;
    forever begin
      if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
      wait_cycles = (recv_calm || no_idle) ? 0 : $urandom_range(0, MAX_WAIT);
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_item(input in_item_t it);
    int wait_cycles;
    if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
    wait_cycles = (send_calm || no_idle) ? 0 : $urandom_range(0, MAX_WAIT);
    if (wait_cycles > 0) begin
      in_valid <= 1'b0;
      repeat (wait_cycles) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_levels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [17:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_settings(input logic [9:0] lo, input logic [9:0] hi,
                                input logic [17:0] corr, input logic [17:0] crit,
                                input logic [17:0] rel, input bit poke_unused);
    drain();
    if (poke_unused) cfg_write(CFG_UNUSED_INDEX, 18'($urandom));
    cfg_write(CFG_MIN_VALID_TARGET, {8'($urandom), lo});
    cfg_write(CFG_MAX_VALID_TARGET, {8'($urandom), hi});
    cfg_write(CFG_CORRECTIVE_RATE_Q8, corr);
    cfg_write(CFG_CRITICAL_RATE_Q8, crit);
    cfg_write(CFG_RELEASE_RATE_Q8, rel);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  function automatic in_item_t eval_sample(input logic [63:0] now, input logic [9:0] target,
                                           input logic [17:0] rate, input logic [2:0] budget);
    in_item_t it;
    it                  = '0;
    it.func             = FUNC_EVAL;
    it.actuator_ok      = 1'b1;
    it.pressure_active  = 1'b1;
    it.target_rate      = target;
    it.measured_rate_q8 = rate;
    it.now_ms           = now;
    it.step_budget      = budget;
    return it;
  endfunction

  function automatic in_item_t sync_sample(input logic [2:0] lvl);
    in_item_t it;
    it                   = '0;
    it.func              = FUNC_SYNC;
    it.observed_level_in = lvl;
    return it;
  endfunction

  function automatic logic [17:0] rate_near(input logic [17:0] base, input int below,
                                            input int above);
    int r;
    r = int'(base) + int'($urandom_range(0, below + above)) - below;
    if (r < 1) r = 1;
    if (r > int'(RATE_MAX)) r = int'(RATE_MAX);
    return r[17:0];
  endfunction

  function automatic in_item_t next_sample();
    in_item_t   it;
    bit [127:0] noise;
    int         lo, hi, pick;
    if (episode_left == 0) begin
      episode      = episode_t'($urandom_range(0, 5));
      episode_left = $urandom_range(3, 25);
      step_max     = ($urandom_range(0, 1) == 0) ? 300 : 2500;
    end
    episode_left--;
    lo   = (sb.min_target == 0) ? 1 : int'(sb.min_target);
    hi   = int'(sb.max_target);
    pick = $urandom_range(0, 99);
    if (lo <= hi && (gen_target < lo || gen_target > hi || pick < 3))
      gen_target = 10'($urandom_range(lo, hi));
    if (pick >= 3 && pick < 5) gen_time = gen_time - 64'($urandom_range(1, 5000));
    else if (pick == 5) gen_time = {$urandom, $urandom};
    else gen_time = gen_time + 64'($urandom_range(0, step_max));
    it                   = eval_sample(gen_time, gen_target, 18'd1, 3'($urandom_range(1, 5)));
    it.load_present      = 1'($urandom_range(0, 1));
    it.load_q10          = ($urandom_range(0, 9) == 0) ? 11'($urandom)
                                                       : 11'($urandom_range(0, int'(LOAD_FULL)));
    it.observed_level_in = 3'($urandom);
    case (episode)
      EP_LOW:
        it.measured_rate_q8 = rate_near(($urandom_range(0, 1) == 0) ? sb.critical_q8
                                                                     : sb.corrective_q8, 300, 100);
      EP_HIGH:
        it.measured_rate_q8 = rate_near(sb.release_q8, 100, 1500);
      EP_MIXED:
        case ($urandom_range(0, 3))
          0:       it.measured_rate_q8 = 18'($urandom);
          1:       it.measured_rate_q8 = RATE_MAX;
          2:       it.measured_rate_q8 = rate_near(sb.corrective_q8, 200, 200);
          default: it.measured_rate_q8 = rate_near(sb.release_q8, 200, 200);
        endcase
      EP_PRESSURE_OFF: begin
        it.pressure_active  = ($urandom_range(0, 9) == 0);
        it.measured_rate_q8 = 18'($urandom);
      end
      EP_TELEMETRY_OFF:
        it.measured_rate_q8 = ($urandom_range(0, 9) == 0) ? rate_near(sb.release_q8, 0, 500)
                                                          : 18'd0;
      default: begin
        noise = {$urandom, $urandom, $urandom, $urandom};
        it    = noise[$bits(in_item_t)-1:0];
        if ($urandom_range(0, 1) == 0) it.now_ms = gen_time;
      end
    endcase
    if (episode != EP_NOISE) begin
      if (pick >= 90 && pick < 96) begin
        it.func              = FUNC_SYNC;
        it.observed_level_in = 3'($urandom_range(0, 7));
      end else if (pick >= 96 && pick < 98) begin
        it.actuator_ok = 1'b0;
      end else if (pick >= 98) begin
        it.step_budget = ($urandom_range(0, 1) == 0) ? 3'd0 : 3'($urandom_range(6, 7));
      end
    end
    return it;
  endfunction

  task automatic run_random(input int count);
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) drain();
      send_item(next_sample());
    end
  endtask

  task automatic run_directed();
    in_item_t it;
    send_item(sync_sample(3'd3));
    send_item(sync_sample(3'd0));
    send_item(sync_sample(3'd7));
    send_item(eval_sample(64'd1000, 10'd60, 18'd13000, 3'd2));
    send_item(eval_sample(64'd1700, 10'd60, 18'd13000, 3'd2));
    send_item(eval_sample(64'd1800, 10'd60, 18'd20000, 3'd1));
    send_item(eval_sample(64'd7000, 10'd60, 18'd20000, 3'd1));
    send_item(eval_sample(64'd7100, 10'd60, 18'd11000, 3'd5));
    send_item(eval_sample(64'd7600, 10'd60, 18'd11000, 3'd5));
    send_item(eval_sample(64'd8000, 10'd60, 18'd0, 3'd3));
    send_item(eval_sample(64'd19000, 10'd60, 18'd0, 3'd3));
    it              = eval_sample(64'd19100, 10'd60, 18'd20000, 3'd3);
    it.load_present = 1'b1;
    it.load_q10     = LOAD_FULL;
    send_item(it);
    it.now_ms = 64'd19800;
    send_item(it);
    it.pressure_active = 1'b0;
    it.now_ms          = 64'd20000;
    send_item(it);
    it.now_ms = 64'd31000;
    send_item(it);
    it.now_ms = 64'd31100;
    send_item(it);
    send_item(eval_sample(64'd32000, 10'd60, 18'd20000, 3'd1));
    send_item(eval_sample(64'd32100, 10'd90, 18'd20000, 3'd1));
    send_item(eval_sample(64'd1000, 10'd90, 18'd20000, 3'd1));
    it             = eval_sample(64'd1100, 10'd90, 18'd20000, 3'd1);
    it.actuator_ok = 1'b0;
    send_item(it);
    it.actuator_ok = 1'b1;
    it.target_rate = 10'd0;
    send_item(it);
    it.target_rate = 10'd29;
    send_item(it);
    it.target_rate = 10'd241;
    send_item(it);
    it.target_rate = 10'd90;
    it.step_budget = 3'd0;
    send_item(it);
    it.step_budget = 3'd6;
    send_item(it);
    it                   = eval_sample('1, 10'd240, RATE_MAX, 3'd5);
    it.load_present      = 1'b1;
    it.load_q10          = 11'h7FF;
    it.observed_level_in = 3'd7;
    send_item(it);
  endtask

  initial begin : stimulus
    logic [9:0]  one_target;
    logic [17:0] crit_rate, corr_rate;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n      <= 1'b1;
    gen_time   = 64'd1;
    gen_target = 10'd60;
    run_directed();
    run_random(400);
    apply_settings(10'd1, 10'd1023, RATE_MAX, 18'd0, RATE_MAX, 1'b0);
    run_random(250);
    apply_settings(10'd0, 10'd1023, 18'd0, RATE_MAX, 18'd0, 1'b0);
    run_random(250);
    apply_settings(10'd600, 10'd100, 18'd14336, 18'd11520, 18'd15616, 1'b0);
    run_random(100);
    one_target = 10'($urandom_range(1, 1023));
    apply_settings(one_target, one_target, 18'($urandom), 18'($urandom), 18'($urandom), 1'b0);
    run_random(300);
    crit_rate = 18'($urandom_range(1000, 20000));
    corr_rate = crit_rate + 18'($urandom_range(0, 5000));
    apply_settings(10'($urandom_range(1, 100)), 10'($urandom_range(100, 1023)),
                   corr_rate, crit_rate, corr_rate + 18'($urandom_range(0, 5000)), 1'b1);
    run_random(350);
    no_idle = 1'b1;
    apply_settings(10'd30, 10'd240, 18'd14336, 18'd11520, 18'd15616, 1'b0);
    run_random(300);
    drain();
    $display("covered %0d items and %0d results over %0d register settings (%0d writes)",
             items_sent, sb.checked, settings_used, cfg_writes);
    if (sb.expected_levels.size() != 0)
      $display("%0d expected results never arrived", sb.expected_levels.size());
    if (sb.mismatches == 0 && sb.expected_levels.size() == 0)
      $display("dwell_hysteresis_level_governor_unit regression: pass");
    else
      $display("dwell_hysteresis_level_governor_unit regression: fail");
    $finish;
  end

endmodule
